>>> src/assert_macros.svh
// Assertion helpers shared by the checker modules.
// ASSERT_CLK: clocked property, disabled while reset is high.
// ASSERT_CLK_NR: clocked property that is also checked during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> src/dwsc_pkg.sv
// ----------------------------------------------------------------------------
// dwsc_pkg
// Types, field widths, register indexes and mode codes of the dual wheel
// speed controller.
// ----------------------------------------------------------------------------
package dwsc_pkg;

  // field widths
  localparam int COUNT_W  = 32;
  localparam int TARGET_W = 16;
  localparam int DRIVE_W  = 9;
  localparam int GAIN_W   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // default output limit
  localparam int unsigned DRIVE_LIMIT_DEF = 255;

  typedef logic signed [COUNT_W-1:0]  count_t;
  typedef logic signed [TARGET_W-1:0] target_t;
  typedef logic signed [DRIVE_W-1:0]  drive_t;
  typedef logic [GAIN_W-1:0]          gain_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PID_SPEED_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PID_INTEGRAL_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PID_DERIVATIVE_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PI_GAIN             = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN              = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SCALE         = 3'd6;

  // control modes; the fourth code drives zero
  localparam logic [1:0] MODE_PID = 2'd0;
  localparam logic [1:0] MODE_PI  = 2'd1;
  localparam logic [1:0] MODE_P   = 2'd2;

  // register reset values
  localparam logic [1:0] MODE_RST        = MODE_PID;
  localparam gain_t SPEED_GAIN_RST       = 16'd256;
  localparam gain_t INTEGRAL_GAIN_RST    = 16'd256;
  localparam gain_t DERIVATIVE_GAIN_RST  = 16'd0;
  localparam gain_t PI_GAIN_RST          = 16'd256;
  localparam gain_t P_GAIN_RST           = 16'd256;
  localparam gain_t PULSE_SCALE_RST      = 16'd6144;

  // register set as seen by the datapath
  typedef struct packed {
    logic [1:0] mode;
    gain_t      speed_gain;
    gain_t      integral_gain;
    gain_t      derivative_gain;
    gain_t      pi_gain;
    gain_t      p_gain;
    gain_t      pulse_scale;
  } dwsc_cfg_t;

endpackage

>>> src/dwsc_tick_if.sv
// ----------------------------------------------------------------------------
// dwsc_tick_if
// Control tick channel: encoder counts, target speeds and clear flag.
// ----------------------------------------------------------------------------
interface dwsc_tick_if import dwsc_pkg::*; ();
  logic    valid;
  logic    ready;
  count_t  count_left;
  count_t  count_right;
  target_t target_left;
  target_t target_right;
  logic    clear_dynamics;

  modport source (
    output valid, count_left, count_right, target_left, target_right, clear_dynamics,
    input  ready
  );
  modport sink (
    input  valid, count_left, count_right, target_left, target_right, clear_dynamics,
    output ready
  );
endinterface

>>> src/dwsc_drive_if.sv
// ----------------------------------------------------------------------------
// dwsc_drive_if
// Drive result channel: one signed drive value per wheel.
// ----------------------------------------------------------------------------
interface dwsc_drive_if import dwsc_pkg::*; ();
  logic   valid;
  logic   ready;
  drive_t drive_left;
  drive_t drive_right;

  modport source (output valid, drive_left, drive_right, input ready);
  modport sink   (input valid, drive_left, drive_right, output ready);
endinterface

>>> src/dwsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dwsc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dwsc_cfg_regs import dwsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output dwsc_cfg_t             cfg
);

  // register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= MODE_RST;
      cfg.speed_gain      <= SPEED_GAIN_RST;
      cfg.integral_gain   <= INTEGRAL_GAIN_RST;
      cfg.derivative_gain <= DERIVATIVE_GAIN_RST;
      cfg.pi_gain         <= PI_GAIN_RST;
      cfg.p_gain          <= P_GAIN_RST;
      cfg.pulse_scale     <= PULSE_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONTROL_MODE:        cfg.mode            <= cfg_data[1:0];
        CFG_PID_SPEED_GAIN:      cfg.speed_gain      <= cfg_data[GAIN_W-1:0];
        CFG_PID_INTEGRAL_GAIN:   cfg.integral_gain   <= cfg_data[GAIN_W-1:0];
        CFG_PID_DERIVATIVE_GAIN: cfg.derivative_gain <= cfg_data[GAIN_W-1:0];
        CFG_PI_GAIN:             cfg.pi_gain         <= cfg_data[GAIN_W-1:0];
        CFG_P_GAIN:              cfg.p_gain          <= cfg_data[GAIN_W-1:0];
        CFG_PULSE_SCALE:         cfg.pulse_scale     <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/dwsc_wheel.sv
// ----------------------------------------------------------------------------
// dwsc_wheel
// One wheel: error stage with the controller state, a stage register, and
// the gain/sum/clamp logic that forms the drive value.
// ----------------------------------------------------------------------------
module dwsc_wheel import dwsc_pkg::*; #(
  parameter int unsigned DRIVE_LIMIT = DRIVE_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  dwsc_cfg_t cfg,
  input  logic      load,
  input  count_t    count,
  input  target_t   target,
  input  logic      clear,
  output drive_t    drive
);

  localparam int SUM_W  = 48;
  localparam int OPND_W = SUM_W + 1;
  localparam int ERR_W  = 32;
  localparam int DIFF_W = ERR_W + 1;
  localparam int ACC_W  = 60;
  localparam int PE_W   = ERR_W + GAIN_W + 1;
  localparam int PD_W   = DIFF_W + GAIN_W + 1;
  localparam int TS_W   = TARGET_W + GAIN_W + 1;
  localparam logic signed [ACC_W-1:0] LIM = ACC_W'(DRIVE_LIMIT);

  // truncating divide by 2^16, result fits 33 bits
  function automatic logic signed [DIFF_W-1:0] tdiv16(input logic signed [OPND_W-1:0] x);
    logic signed [OPND_W-1:0] q;
    q = x >>> 16;
    if (x[OPND_W-1] && (|x[15:0])) q = q + OPND_W'(1);
    return q[DIFF_W-1:0];
  endfunction

  // saturate 33 bits to 32 bits signed
  function automatic logic signed [ERR_W-1:0] sat32(input logic signed [DIFF_W-1:0] x);
    if (x[DIFF_W-1] != x[ERR_W-1])
      return x[DIFF_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
    return x[ERR_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] tdiv_acc(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] q;
    q = x >>> 16;
    if (x[ACC_W-1] && (|x[15:0])) q = q + ACC_W'(1);
    return q;
  endfunction

  function automatic logic signed [PE_W-1:0] tdiv_pe(input logic signed [PE_W-1:0] x);
    logic signed [PE_W-1:0] q;
    q = x >>> 8;
    if (x[PE_W-1] && (|x[7:0])) q = q + PE_W'(1);
    return q;
  endfunction

  function automatic drive_t clamp_drive(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] c;
    c = x;
    if (x > LIM) c = LIM;
    else if (x < -LIM) c = -LIM;
    return c[DRIVE_W-1:0];
  endfunction

  // controller state
  logic signed [SUM_W-1:0] sum;
  logic signed [ERR_W-1:0] last_err;
  count_t                  last_cnt;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [ERR_W-1:0] last_err_next;
  count_t                  last_cnt_next;

  // stage register
  logic signed [ERR_W-1:0]  err_q;
  logic signed [DIFF_W-1:0] diff_q;
  target_t                  target_q;
  logic [1:0]               mode_q;

  logic signed [SUM_W-1:0]  sum_eff;
  logic signed [ERR_W-1:0]  last_err_eff;
  count_t                   last_cnt_eff;
  logic signed [TS_W-1:0]   req_prod;
  logic signed [DIFF_W-1:0] req;
  count_t                   delta;
  logic signed [OPND_W-1:0] opnd;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;

  // error stage: required pulses, pulse error, state update
  always_comb begin
    sum_eff      = clear ? '0 : sum;
    last_err_eff = clear ? '0 : last_err;
    last_cnt_eff = clear ? '0 : last_cnt;

    req_prod = target * $signed({1'b0, cfg.pulse_scale});
    req      = DIFF_W'(req_prod >>> 4);
    if (req_prod[TS_W-1] && (|req_prod[3:0])) req = req + DIFF_W'(1);

    delta = count - last_cnt_eff;
    if (cfg.mode == MODE_P)
      opnd = OPND_W'(req) - (OPND_W'(delta) <<< 16);
    else
      opnd = OPND_W'(sum_eff) - (OPND_W'(count) <<< 16);
    err  = sat32(tdiv16(opnd));
    diff = DIFF_W'(err) - DIFF_W'(last_err_eff);

    sum_next      = sum_eff;
    last_err_next = last_err_eff;
    last_cnt_next = last_cnt_eff;
    case (cfg.mode)
      MODE_PID: begin
        sum_next      = sum_eff + SUM_W'(req);
        last_err_next = err;
      end
      MODE_PI: sum_next = sum_eff + SUM_W'(req);
      MODE_P:  last_cnt_next = count;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      last_err <= '0;
      last_cnt <= '0;
    end else if (load) begin
      sum      <= sum_next;
      last_err <= last_err_next;
      last_cnt <= last_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      err_q    <= err;
      diff_q   <= diff;
      target_q <= target;
      mode_q   <= cfg.mode;
    end
  end

  // drive stage: shared error multiplier, feedforward and derivative terms
  gain_t                   err_gain;
  logic signed [PE_W-1:0]  pe;
  logic signed [PD_W-1:0]  pd;
  logic signed [TS_W-1:0]  ts;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] val;

  always_comb begin
    case (mode_q)
      MODE_PID: err_gain = cfg.integral_gain;
      MODE_PI:  err_gain = cfg.pi_gain;
      default:  err_gain = cfg.p_gain;
    endcase
    pe  = err_q * $signed({1'b0, err_gain});
    pd  = diff_q * $signed({1'b0, cfg.derivative_gain});
    ts  = target_q * $signed({1'b0, cfg.speed_gain});
    acc = ACC_W'(ts) + (ACC_W'(pe) <<< 8) + (ACC_W'(pd) <<< 8);
    case (mode_q)
      MODE_PID: val = tdiv_acc(acc);
      MODE_PI:  val = ACC_W'(tdiv_pe(pe));
      MODE_P:   val = ACC_W'(tdiv_pe(pe));
      default:  val = '0;
    endcase
    drive = clamp_drive(val);
  end

endmodule

>>> src/dual_wheel_speed_controller.sv
// ----------------------------------------------------------------------------
// dual_wheel_speed_controller
// Two wheel speed controller (PID, PI and per-tick P modes) with a
// three-register pipeline: input, error stage, drive result.
//
//   channel  dir  handshake        payload
//   tick     in   valid/ready      count_left/right, target_left/right,
//                                  clear_dynamics
//   drive    out  valid/ready      drive_left, drive_right
//   cfg      in   cfg_we only      cfg_index, cfg_data
//
// One tick per cycle while results are taken; a tick passes the input,
// error stage and result registers. The accumulated pulse sum, last error
// and last count update as the error stage loads, so the next tick sees them.
// Reset clears the valid bits and wheel state and resets the config registers.
// Each stage moves when the one after it is free, so ticks keep coming in
// while a result waits, until all three registers hold items.
// ----------------------------------------------------------------------------
module dual_wheel_speed_controller import dwsc_pkg::*; #(
  parameter int unsigned DRIVE_LIMIT = DRIVE_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dwsc_tick_if.sink             tick,
  dwsc_drive_if.source          drive
);

  dwsc_cfg_t cfg;

  dwsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline flow control
  logic in_v, mid_v, out_v;
  logic out_free, mid_free, in_free;
  logic mid_load;

  assign out_free   = !out_v || drive.ready;
  assign mid_free   = !mid_v || out_free;
  assign in_free    = !in_v || mid_free;
  assign mid_load   = mid_free && in_v;
  assign tick.ready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      mid_v <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (in_free)  in_v  <= tick.valid;
      if (mid_free) mid_v <= in_v;
      if (out_free) out_v <= mid_v;
    end
  end

  // input register
  count_t  cnt_l, cnt_r;
  target_t tgt_l, tgt_r;
  logic    clr;

  always_ff @(posedge clk) begin
    if (in_free && tick.valid) begin
      cnt_l <= tick.count_left;
      cnt_r <= tick.count_right;
      tgt_l <= tick.target_left;
      tgt_r <= tick.target_right;
      clr   <= tick.clear_dynamics;
    end
  end

  // wheel datapaths
  drive_t drv_l, drv_r;

  dwsc_wheel #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_left (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .load   (mid_load),
    .count  (cnt_l),
    .target (tgt_l),
    .clear  (clr),
    .drive  (drv_l)
  );

  dwsc_wheel #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_right (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .load   (mid_load),
    .count  (cnt_r),
    .target (tgt_r),
    .clear  (clr),
    .drive  (drv_r)
  );

  // result register
  always_ff @(posedge clk) begin
    if (out_free && mid_v) begin
      drive.drive_left  <= drv_l;
      drive.drive_right <= drv_r;
    end
  end

  assign drive.valid = out_v;

endmodule

>>> src/dwsc_checker.sv
// ----------------------------------------------------------------------------
// dwsc_checker
// Port-level checks of the speed controller: results only for taken ticks,
// bounded occupancy, drive range and stall behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dwsc_checker import dwsc_pkg::*; #(
  parameter int unsigned DRIVE_LIMIT = DRIVE_LIMIT_DEF
) (
  input logic   clk,
  input logic   rst,
  input logic   tick_valid,
  input logic   tick_ready,
  input logic   drive_valid,
  input logic   drive_ready,
  input drive_t drive_left,
  input drive_t drive_right
);

  localparam int LIM = int'(DRIVE_LIMIT);

  // beats taken in minus beats delivered
  logic [2:0] inflight;
  logic       tick_beat, drive_beat;

  assign tick_beat  = tick_valid && tick_ready;
  assign drive_beat = drive_valid && drive_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(tick_beat) - 3'(drive_beat);
    end
  end

  `ASSERT_CLK_NR(a_reset_empty, clk, rst |=> !drive_valid, "result valid after reset")

  `ASSERT_CLK(a_no_phantom, clk, rst, drive_valid |-> inflight != 3'd0, "result without a tick")

  `ASSERT_CLK(a_depth, clk, rst, inflight <= 3'd3, "more ticks in flight than stages")

  `ASSERT_CLK(a_range, clk, rst, drive_valid |-> (LIM > 255) || ((int'(drive_left) <= LIM) && (int'(drive_left) >= -LIM) && (int'(drive_right) <= LIM) && (int'(drive_right) >= -LIM)), "drive out of range")

  `ASSERT_CLK(a_hold, clk, rst, drive_valid && !drive_ready |=> drive_valid && $stable(drive_left) && $stable(drive_right), "stalled result changed")

endmodule

bind dual_wheel_speed_controller dwsc_checker #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_dwsc_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick.valid),
  .tick_ready  (tick.ready),
  .drive_valid (drive.valid),
  .drive_ready (drive.ready),
  .drive_left  (drive.drive_left),
  .drive_right (drive.drive_right)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual wheel speed controller. Ticks go in over
// the tick channel with random gaps; drive results come back under random
// receiver stalls. A local model of both wheels predicts every drive pair,
// and each result beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dwsc_pkg::*;

  localparam int unsigned DRV_LIM = DRIVE_LIMIT_DEF;
  localparam int PIPE_DEPTH = 3;
  localparam int PHASE_ITEMS = 165;

  // fourth mode code and the index with no register behind it
  localparam logic [1:0] MODE_OFF = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam count_t  CNT_MAX = 32'sh7fffffff;
  localparam count_t  CNT_MIN = 32'sh80000000;
  localparam target_t TGT_MAX = 16'sh7fff;
  localparam target_t TGT_MIN = 16'sh8000;

  localparam dwsc_cfg_t CFG_DEFAULTS = '{MODE_RST, SPEED_GAIN_RST, INTEGRAL_GAIN_RST,
                                         DERIVATIVE_GAIN_RST, PI_GAIN_RST, P_GAIN_RST,
                                         PULSE_SCALE_RST};

  typedef struct {
    count_t  count_left;
    count_t  count_right;
    target_t target_left;
    target_t target_right;
    logic    clear_dynamics;
  } tick_t;

  typedef struct {
    drive_t drive_left;
    drive_t drive_right;
  } drive_pair_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dwsc_tick_if  tick_ch ();
  dwsc_drive_if drive_ch ();

  dual_wheel_speed_controller #(
    .DRIVE_LIMIT (DRV_LIM)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .drive     (drive_ch)
  );

  always #10 clk = ~clk;

  // model state: registers and per-wheel dynamics
  dwsc_cfg_t regs;
  longint    req_sum [2];
  int        last_err [2];
  int        last_cnt [2];

  drive_pair_t expected_drives [$];
  drive_pair_t drive_exp;
  int          mismatches = 0;

  // traffic shaping
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int sink_hold_req = 0;

  // simple wheel plant used to build well-formed count sequences
  longint  plant_pos [2] = '{0, 0};
  target_t plant_tgt [2] = '{16'sd0, 16'sd0};

  // --------------------------------------------------------------------------
  // Drive prediction
  // --------------------------------------------------------------------------
  function automatic longint wrap48(input longint x);
    logic signed [47:0] v;
    v = x[47:0];
    return longint'(v);
  endfunction

  function automatic int sat32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic drive_t limit_drive(input longint x);
    longint lim;
    lim = longint'(DRV_LIM);
    if (x > lim) x = lim;
    else if (x < -lim) x = -lim;
    return drive_t'(x);
  endfunction

  function automatic void clear_wheels();
    for (int w = 0; w < 2; w++) begin
      req_sum[w]  = 0;
      last_err[w] = 0;
      last_cnt[w] = 0;
    end
  endfunction

  function automatic drive_t wheel_drive(input int w, input target_t tgt, input count_t cnt);
    longint target, req, acc, delta;
    int     d32;
    int     err;
    target = longint'(tgt);
    // required pulses per tick, Q.16
    req = (target * longint'(regs.pulse_scale)) / 16;
    if (regs.mode == MODE_P) begin
      d32 = cnt - last_cnt[w];
      delta = longint'(d32);
      last_cnt[w] = cnt;
      err = sat32((req - delta * 65536) / 65536);
      return limit_drive((longint'(err) * longint'(regs.p_gain)) / 256);
    end
    if (regs.mode == MODE_OFF) return '0;
    err = sat32((req_sum[w] - longint'(cnt) * 65536) / 65536);
    if (regs.mode == MODE_PID) begin
      acc = target * longint'(regs.speed_gain)
          + 256 * (longint'(err) * longint'(regs.integral_gain))
          + 256 * ((longint'(err) - longint'(last_err[w])) * longint'(regs.derivative_gain));
      last_err[w] = err;
      acc = acc / 65536;
    end else begin
      acc = (longint'(err) * longint'(regs.pi_gain)) / 256;
    end
    req_sum[w] = wrap48(req_sum[w] + req);
    return limit_drive(acc);
  endfunction

  function automatic void predict_drive(input tick_t t);
    drive_pair_t e;
    if (t.clear_dynamics) clear_wheels();
    e.drive_left  = wheel_drive(0, t.target_left, t.count_left);
    e.drive_right = wheel_drive(1, t.target_right, t.count_right);
    expected_drives.push_back(e);
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic gain_t pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 65) return gain_t'($urandom_range(64, 1024));
    return gain_t'($urandom());
  endfunction

  // tracking ticks follow the plant; a share are raw noise
  function automatic tick_t next_random_tick(input bit force_clear);
    tick_t  t;
    count_t cnt [2];
    int     r;
    r = $urandom_range(0, 99);
    if (!force_clear && r >= 85) begin
      t.count_left     = count_t'($urandom());
      t.count_right    = count_t'($urandom());
      t.target_left    = target_t'($urandom());
      t.target_right   = target_t'($urandom());
      t.clear_dynamics = 1'($urandom_range(0, 1));
      return t;
    end
    t.clear_dynamics = force_clear || (r < 6);
    for (int w = 0; w < 2; w++) begin
      if (t.clear_dynamics) plant_pos[w] = longint'(int'($urandom_range(0, 6)) - 3);
      if ($urandom_range(0, 99) < 8)
        plant_tgt[w] = ($urandom_range(0, 4) == 0) ? target_t'($urandom())
                     : target_t'(int'($urandom_range(0, 51200)) - 25600);
      cnt[w] = count_t'(plant_pos[w]);
      plant_pos[w] += (longint'(plant_tgt[w]) * longint'(regs.pulse_scale) / 16) / 65536
                    + int'($urandom_range(0, 8)) - 4;
    end
    t.count_left   = cnt[0];
    t.count_right  = cnt[1];
    t.target_left  = plant_tgt[0];
    t.target_right = plant_tgt[1];
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Channel and register access
  // --------------------------------------------------------------------------
  task automatic send_tick(input tick_t t);
    tick_ch.valid          <= 1'b1;
    tick_ch.count_left     <= t.count_left;
    tick_ch.count_right    <= t.count_right;
    tick_ch.target_left    <= t.target_left;
    tick_ch.target_right   <= t.target_right;
    tick_ch.clear_dynamics <= t.clear_dynamics;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    predict_drive(t);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      tick_ch.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // stop sending and wait for every predicted beat to come back
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_CONTROL_MODE:        regs.mode            = data[1:0];
      CFG_PID_SPEED_GAIN:      regs.speed_gain      = data;
      CFG_PID_INTEGRAL_GAIN:   regs.integral_gain   = data;
      CFG_PID_DERIVATIVE_GAIN: regs.derivative_gain = data;
      CFG_PI_GAIN:             regs.pi_gain         = data;
      CFG_P_GAIN:              regs.p_gain          = data;
      CFG_PULSE_SCALE:         regs.pulse_scale     = data;
      default: ;
    endcase
  endtask

  // full register set, written only once the block is idle
  task automatic program_regs(input dwsc_cfg_t c, input bit poke_unused);
    logic [13:0] pad;
    drain_results();
    pad = 14'($urandom());
    write_reg(CFG_CONTROL_MODE, {pad, c.mode});
    write_reg(CFG_PID_SPEED_GAIN, c.speed_gain);
    write_reg(CFG_PID_INTEGRAL_GAIN, c.integral_gain);
    write_reg(CFG_PID_DERIVATIVE_GAIN, c.derivative_gain);
    write_reg(CFG_PI_GAIN, c.pi_gain);
    write_reg(CFG_P_GAIN, c.p_gain);
    write_reg(CFG_PULSE_SCALE, c.pulse_scale);
    if (poke_unused) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // register reset values, field extremes, clear requests
  task automatic test_reset_values();
    src_idle_pct  = 25;
    sink_idle_pct = 25;
    send_tick('{32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b1});
    send_tick('{32'sd0, 32'sd0, TGT_MAX, TGT_MIN, 1'b0});
    send_tick('{CNT_MAX, CNT_MIN, 16'sd0, 16'sd0, 1'b0});
    send_tick('{CNT_MIN, CNT_MAX, TGT_MIN, TGT_MAX, 1'b0});
    send_tick('{32'sd100, -32'sd100, 16'sd25600, -16'sd25600, 1'b0});
    send_tick('{32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b1});
  endtask

  // each mode, including the unused code, against the same corner ticks
  task automatic test_mode_corners();
    logic [1:0] corner_modes [4];
    dwsc_cfg_t  c;
    corner_modes = '{MODE_PID, MODE_PI, MODE_P, MODE_OFF};
    foreach (corner_modes[i]) begin
      c = CFG_DEFAULTS;
      c.mode = corner_modes[i];
      c.derivative_gain = 16'd512;
      program_regs(c, 1'b0);
      send_tick('{32'sd0, 32'sd0, TGT_MAX, TGT_MIN, 1'b1});
      send_tick('{CNT_MAX, CNT_MIN, TGT_MAX, TGT_MIN, 1'b0});
      send_tick('{CNT_MIN, CNT_MAX, TGT_MIN, TGT_MAX, 1'b0});
      send_tick('{32'sd50, -32'sd50, 16'sd12800, -16'sd12800, 1'b0});
    end
  endtask

  // a write to the free index must leave every register alone
  task automatic test_unused_register();
    program_regs(CFG_DEFAULTS, 1'b1);
    send_tick('{32'sd7, -32'sd7, 16'sd2560, -16'sd2560, 1'b0});
    send_tick('{32'sd20, -32'sd20, 16'sd2560, -16'sd2560, 1'b0});
  endtask

  // receiver holds off while ticks keep coming, so the pipe fills and stalls
  task automatic test_backpressure();
    dwsc_cfg_t c;
    c = CFG_DEFAULTS;
    c.derivative_gain = 16'd128;
    program_regs(c, 1'b0);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sink_hold_req = 60;
    for (int i = 0; i < 16; i++) send_tick(next_random_tick(i == 0));
    drain_results();
    sink_hold_req = 40;
    for (int i = 0; i < 8; i++) send_tick(next_random_tick(1'b0));
    drain_results();
  endtask

  // random phases over several register settings, extremes first
  task automatic test_random_phases();
    logic [1:0] mode_cycle [3];
    dwsc_cfg_t  c;
    mode_cycle = '{MODE_PID, MODE_PI, MODE_P};
    for (int ph = 0; ph < 10; ph++) begin
      c.mode = (ph == 7) ? MODE_OFF : mode_cycle[ph % 3];
      if (ph == 0) begin
        c.speed_gain = '1; c.integral_gain = '1; c.derivative_gain = '1;
        c.pi_gain = '1; c.p_gain = '1; c.pulse_scale = '1;
      end else if (ph == 1) begin
        c.speed_gain = '0; c.integral_gain = '0; c.derivative_gain = '0;
        c.pi_gain = '0; c.p_gain = '0; c.pulse_scale = '0;
      end else begin
        c.speed_gain      = pick_gain();
        c.integral_gain   = pick_gain();
        c.derivative_gain = pick_gain();
        c.pi_gain         = pick_gain();
        c.p_gain          = pick_gain();
        c.pulse_scale     = pick_gain();
      end
      program_regs(c, ph == 5);
      // one phase runs with no idling at all
      src_idle_pct  = (ph == 2) ? 0 : $urandom_range(5, 50);
      sink_idle_pct = (ph == 2) ? 0 : $urandom_range(5, 50);
      for (int i = 0; i < PHASE_ITEMS; i++) send_tick(next_random_tick(i == 0));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver ready: random stalls, plus long hold-offs on request
  // --------------------------------------------------------------------------
  initial begin : sink_ctrl
    int stall_left;
    stall_left = 0;
    drive_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        stall_left = sink_hold_req;
        sink_hold_req = 0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        drive_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        drive_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every drive beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      if (expected_drives.size() == 0) begin
        $error("drive beat with no tick waiting: left %0d right %0d",
               drive_ch.drive_left, drive_ch.drive_right);
        mismatches++;
      end else begin
        drive_exp = expected_drives.pop_front();
        if (drive_ch.drive_left !== drive_exp.drive_left) begin
          $error("drive_left: expected %0d, actual %0d",
                 drive_exp.drive_left, drive_ch.drive_left);
          mismatches++;
        end
        if (drive_ch.drive_right !== drive_exp.drive_right) begin
          $error("drive_right: expected %0d, actual %0d",
                 drive_exp.drive_right, drive_ch.drive_right);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= '0;
    cfg_data               <= '0;
    tick_ch.valid          <= 1'b0;
    tick_ch.count_left     <= '0;
    tick_ch.count_right    <= '0;
    tick_ch.target_left    <= '0;
    tick_ch.target_right   <= '0;
    tick_ch.clear_dynamics <= 1'b0;
    regs = CFG_DEFAULTS;
    clear_wheels();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_mode_corners();
    test_unused_register();
    test_backpressure();
    test_random_phases();

    drain_results();
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("dual_wheel_speed_controller: match");
    end else begin
      $display("dual_wheel_speed_controller: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(50_000_000);
    $display("dual_wheel_speed_controller: mismatch");
    $finish;
  end

endmodule
